FILE: hw/rtl/ehs_pkg.sv
package ehs_pkg;

    // Fixed field widths
    localparam int PIXEL_W     = 8;
    localparam int CFG_SIZE_W  = 10;
    localparam int THRESH_W    = 8;
    localparam int BIN_IDX_W   = 9;
    localparam int SUM_W       = 17;

    // APB register map, one 32-bit word per register
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 4;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GRAD_THRESH  = 2'd2;

    localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RST  = 10'd512;
    localparam logic [CFG_SIZE_W-1:0] IMAGE_HEIGHT_RST = 10'd512;
    localparam logic [THRESH_W-1:0]   GRAD_THRESH_RST  = 8'd0;

    // Histogram kinds
    localparam logic KIND_HORIZONTAL = 1'b0;
    localparam logic KIND_VERTICAL   = 1'b1;

    // Result queue
    localparam int BIN_FIFO_DEPTH = 8;
    localparam int BIN_FIFO_PTR_W = 3;
    localparam int BIN_FIFO_CNT_W = 4;

    typedef logic [PIXEL_W-1:0]   t_pixel;
    typedef logic [BIN_IDX_W-1:0] t_bin_idx;
    typedef logic [SUM_W-1:0]     t_sum;

    typedef struct packed {
        logic     histogram_kind;
        t_bin_idx bin_index;
        t_sum     bin_value;
        logic     frame_last;
    } t_bin;

endpackage

FILE: hw/rtl/ehs_pixel_if.sv
interface ehs_pixel_if import ehs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: hw/rtl/ehs_bin_if.sv
interface ehs_bin_if import ehs_pkg::*; ();
    logic     valid;
    logic     ready;
    logic     histogram_kind;
    t_bin_idx bin_index;
    t_sum     bin_value;
    logic     frame_last;

    modport source (output valid, output histogram_kind, output bin_index,
                    output bin_value, output frame_last, input ready);
    modport sink   (input valid, input histogram_kind, input bin_index,
                    input bin_value, input frame_last, output ready);
endinterface

FILE: hw/rtl/ehs_bin_fifo.sv
module ehs_bin_fifo import ehs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [1:0]                i_wr_en,
    input  t_bin                      i_wr_data0,
    input  t_bin                      i_wr_data1,
    output logic [BIN_FIFO_CNT_W-1:0] o_count,
    ehs_bin_if.source                 o_bin
);

    t_bin                      r_mem [BIN_FIFO_DEPTH];
    logic [BIN_FIFO_PTR_W-1:0] r_wr_ptr;
    logic [BIN_FIFO_PTR_W-1:0] r_rd_ptr;
    logic [BIN_FIFO_CNT_W-1:0] r_count;
    logic [BIN_FIFO_CNT_W-1:0] n_count;
    logic [BIN_FIFO_PTR_W-1:0] wr_ptr_p1;
    logic [BIN_FIFO_CNT_W-1:0] push_cnt;
    logic                      pop;
    t_bin                      head;

    assign wr_ptr_p1 = r_wr_ptr + BIN_FIFO_PTR_W'(1);
    assign push_cnt  = BIN_FIFO_CNT_W'(i_wr_en[0]) + BIN_FIFO_CNT_W'(i_wr_en[1]);
    assign pop       = o_bin.valid & o_bin.ready;
    assign n_count   = r_count + push_cnt - BIN_FIFO_CNT_W'(pop);

    // Storage, up to two beats written per cycle (second only with first)
    always_ff @(posedge i_clk) begin
        if (i_wr_en[0]) begin
            r_mem[r_wr_ptr] <= i_wr_data0;
        end
        if (i_wr_en[1]) begin
            r_mem[wr_ptr_p1] <= i_wr_data1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + BIN_FIFO_PTR_W'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + BIN_FIFO_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Head of queue drives the output channel
    assign head                 = r_mem[r_rd_ptr];
    assign o_bin.valid          = (r_count != '0);
    assign o_bin.histogram_kind = head.histogram_kind;
    assign o_bin.bin_index      = head.bin_index;
    assign o_bin.bin_value      = head.bin_value;
    assign o_bin.frame_last     = head.frame_last;
    assign o_count              = r_count;

endmodule

FILE: hw/rtl/edge_histogram_stream.sv
// A pixel's result beats pass through the stage-1 registers and then the result queue to o_bin.
// Throughput: one pixel per cycle; a row end on the last row yields two beats into an
// 8-entry result queue. i_pix.ready drops while the queued beats, plus two for a pixel
// in stage 1, exceed four; with o_bin always ready it stays high.
// Reset (i_rst_n low, synchronous): counters, row sum, left pixels, queue cleared; width
// and height return to 512, threshold to 0. Line and column-sum memories are not cleared.
module edge_histogram_stream import ehs_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ehs_pixel_if.sink             i_pix,
    ehs_bin_if.source             o_bin,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WSZ_W = (CFG_SIZE_W > $clog2(MAX_WIDTH + 1)) ?
                           CFG_SIZE_W : $clog2(MAX_WIDTH + 1);
    localparam int HSZ_W = (CFG_SIZE_W > $clog2(MAX_HEIGHT + 1)) ?
                           CFG_SIZE_W : $clog2(MAX_HEIGHT + 1);

    // Thresholded absolute difference
    function automatic t_pixel grad_term(t_pixel a, t_pixel b, t_pixel thr);
        t_pixel d;
        d = (a > b) ? (a - b) : (b - a);
        return (d > thr) ? d : '0;
    endfunction

    // Saturating accumulate
    function automatic t_sum sat_add(t_sum a, t_pixel b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [CFG_SIZE_W-1:0] r_frame_width;
    logic [CFG_SIZE_W-1:0] r_image_height;
    t_pixel                r_grad_thresh;
    logic                  apb_wr;
    logic [REG_IDX_W-1:0]  reg_idx;

    assign pready  = 1'b1;
    assign apb_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_grad_thresh  <= GRAD_THRESH_RST;
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_SIZE_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[CFG_SIZE_W-1:0];
                REG_GRAD_THRESH:  r_grad_thresh  <= pwdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            REG_GRAD_THRESH:  prdata = APB_DATA_W'(r_grad_thresh);
            default:          prdata = '0;
        endcase
    end

    // ---------------- stage 0: accept, count, issue memory reads ----------------
    logic                       accept;
    logic [CW-1:0]              r_col_cnt;
    logic [RW-1:0]              r_row_cnt;
    logic [WSZ_W-1:0]           w_raw;
    logic [WSZ_W-1:0]           w_eff;
    logic [HSZ_W-1:0]           h_raw;
    logic [HSZ_W-1:0]           h_eff;
    logic                       s0_row_end;
    logic                       s0_last_row;
    logic [CW-1:0]              s0_col_m1;
    logic [BIN_FIFO_CNT_W-1:0]  fifo_count;
    logic [BIN_FIFO_CNT_W-1:0]  fifo_need;

    // Sizes saturated into the supported range
    assign w_raw = WSZ_W'(r_frame_width);
    assign h_raw = HSZ_W'(r_image_height);
    assign w_eff = (w_raw < WSZ_W'(3)) ? WSZ_W'(3) :
                   (w_raw > WSZ_W'(MAX_WIDTH)) ? WSZ_W'(MAX_WIDTH) : w_raw;
    assign h_eff = (h_raw < HSZ_W'(3)) ? HSZ_W'(3) :
                   (h_raw > HSZ_W'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) : h_raw;

    assign s0_row_end  = (WSZ_W'(r_col_cnt) >= (w_eff - WSZ_W'(1)));
    assign s0_last_row = (HSZ_W'(r_row_cnt) >= (h_eff - HSZ_W'(1)));
    assign s0_col_m1   = r_col_cnt - CW'(1);

    // Room for this beat's results plus those still in stage 1
    logic r_s1_valid;
    assign fifo_need   = fifo_count + (r_s1_valid ? BIN_FIFO_CNT_W'(2) : '0);
    assign i_pix.ready = (fifo_need <= BIN_FIFO_CNT_W'(BIN_FIFO_DEPTH - 4));
    assign accept      = i_pix.valid & i_pix.ready;

    // Raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (accept) begin
            if (s0_row_end) begin
                r_col_cnt <= '0;
                r_row_cnt <= s0_last_row ? '0 : r_row_cnt + RW'(1);
            end else begin
                r_col_cnt <= r_col_cnt + CW'(1);
            end
        end
    end

    // Line store {older, newer} and per-column sums
    logic [2*PIXEL_W-1:0] r_line_mem   [MAX_WIDTH];
    t_sum                 r_colsum_mem [MAX_WIDTH];
    logic [2*PIXEL_W-1:0] r_line_q;
    t_sum                 r_colsum_q;

    // Stage 1 payload
    t_pixel        r_s1_pixel;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic          r_s1_row_end;
    logic          r_s1_last_row;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_q      <= r_line_mem[r_col_cnt];
            r_colsum_q    <= r_colsum_mem[s0_col_m1];
            r_s1_pixel    <= i_pix.pixel;
            r_s1_col      <= r_col_cnt;
            r_s1_row      <= r_row_cnt;
            r_s1_row_end  <= s0_row_end;
            r_s1_last_row <= s0_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    // ---------------- stage 1: gradients, accumulate, emit ----------------
    t_pixel        r_left_one;
    t_pixel        r_left_two;
    t_sum          r_row_sum;
    logic [CW-1:0] s1_col_m1;
    logic          s1_col_ge2;
    logic          s1_row_ge2;
    logic          s1_row_zero;
    t_pixel        h_term;
    t_pixel        v_term;
    t_sum          h_sum;
    t_sum          v_sum;
    logic          h_emit;
    logic          v_emit;
    t_bin          h_bin;
    t_bin          v_bin;

    assign s1_col_m1   = r_s1_col - CW'(1);
    assign s1_col_ge2  = (r_s1_col >= CW'(2));
    assign s1_row_ge2  = (r_s1_row >= RW'(2));
    assign s1_row_zero = (r_s1_row == '0);

    assign h_term = grad_term(r_s1_pixel, r_left_two, r_grad_thresh);
    assign v_term = grad_term(r_s1_pixel, r_line_q[2*PIXEL_W-1:PIXEL_W], r_grad_thresh);
    assign h_sum  = s1_row_zero ? SUM_W'(h_term) : sat_add(r_colsum_q, h_term);
    assign v_sum  = s1_row_ge2 ? sat_add(r_row_sum, v_term) : r_row_sum;

    assign h_emit = r_s1_valid & s1_col_ge2 & r_s1_last_row;
    assign v_emit = r_s1_valid & r_s1_row_end & s1_row_ge2;

    always_comb begin
        h_bin.histogram_kind = KIND_HORIZONTAL;
        h_bin.bin_index      = BIN_IDX_W'(s1_col_m1);
        h_bin.bin_value      = h_sum;
        h_bin.frame_last     = 1'b0;
        v_bin.histogram_kind = KIND_VERTICAL;
        v_bin.bin_index      = BIN_IDX_W'(r_s1_row - RW'(1));
        v_bin.bin_value      = v_sum;
        v_bin.frame_last     = r_s1_last_row;
    end

    // Memory write-back
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= {r_line_q[PIXEL_W-1:0], r_s1_pixel};
            if (s1_col_ge2) begin
                r_colsum_mem[s1_col_m1] <= h_sum;
            end
        end
    end

    // Left-pixel shift and row accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_one <= '0;
            r_left_two <= '0;
            r_row_sum  <= '0;
        end else if (r_s1_valid) begin
            r_left_two <= r_left_one;
            r_left_one <= r_s1_pixel;
            r_row_sum  <= r_s1_row_end ? '0 : v_sum;
        end
    end

    // Result queue: horizontal bin first when both fire
    ehs_bin_fifo u_bin_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    ({h_emit & v_emit, h_emit | v_emit}),
        .i_wr_data0 (h_emit ? h_bin : v_bin),
        .i_wr_data1 (v_bin),
        .o_count    (fifo_count),
        .o_bin      (o_bin)
    );

endmodule
